FILE: rtl/rigid_body_state_tolerance_compare_assert.svh
// Assertion macros for the block's top-level RTL file.
`ifndef RIGID_BODY_STATE_TOLERANCE_COMPARE_ASSERT_SVH
`define RIGID_BODY_STATE_TOLERANCE_COMPARE_ASSERT_SVH

`ifndef ASSERT_OFF
`define RBSTC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RBSTC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBSTC_ASSERT(lbl, prop, msg)
`define RBSTC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/rbstc_pkg.sv
`default_nettype none

package rbstc_pkg;

    localparam int LANE_W = 16;
    localparam int VEC_W  = 3 * LANE_W;
    localparam int ROT_W  = 4 * LANE_W;
    localparam int TOL_W  = 16;
    localparam int SQ_W   = 2 * TOL_W;
    localparam int ROT_SHIFT = 14;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int SUM_W = 2 * LANE_W + 2;
    localparam int CMP_W = SUM_W + 1;
    localparam logic [CMP_W-1:0] ONE_Q28 = CMP_W'(1) << 28;

    typedef enum logic [1:0] {
        REG_POSITION = 2'd0,
        REG_ROTATION = 2'd1,
        REG_VELOCITY = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [VEC_W-1:0] first_position;
        logic [VEC_W-1:0] second_position;
        logic [ROT_W-1:0] first_rotation;
        logic [ROT_W-1:0] second_rotation;
        logic [VEC_W-1:0] first_linear_velocity;
        logic [VEC_W-1:0] second_linear_velocity;
        logic [VEC_W-1:0] first_angular_velocity;
        logic [VEC_W-1:0] second_angular_velocity;
    } req_t;

    typedef struct packed {
        logic [SQ_W-1:0]  position_sq;
        logic [SQ_W-1:0]  velocity_sq;
        logic [TOL_W-1:0] rotation;
    } tol_t;

endpackage

`default_nettype wire

FILE: rtl/rbstc_if.sv
`default_nettype none

interface rbstc_req_if;
    import rbstc_pkg::*;

    logic             valid;
    logic             ready;
    logic [VEC_W-1:0] first_position;
    logic [VEC_W-1:0] second_position;
    logic [ROT_W-1:0] first_rotation;
    logic [ROT_W-1:0] second_rotation;
    logic [VEC_W-1:0] first_linear_velocity;
    logic [VEC_W-1:0] second_linear_velocity;
    logic [VEC_W-1:0] first_angular_velocity;
    logic [VEC_W-1:0] second_angular_velocity;

    modport source (
        output valid, first_position, second_position, first_rotation, second_rotation,
               first_linear_velocity, second_linear_velocity,
               first_angular_velocity, second_angular_velocity,
        input  ready
    );

    modport sink (
        input  valid, first_position, second_position, first_rotation, second_rotation,
               first_linear_velocity, second_linear_velocity,
               first_angular_velocity, second_angular_velocity,
        output ready
    );
endinterface

interface rbstc_res_if;
    logic valid;
    logic ready;
    logic states_match;

    modport source (output valid, states_match, input ready);
    modport sink (input valid, states_match, output ready);
endinterface

`default_nettype wire

FILE: rtl/rbstc_cfg.sv
`default_nettype none

module rbstc_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rbstc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [rbstc_pkg::DATA_W-1:0] pwdata,
    output logic      [rbstc_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output rbstc_pkg::tol_t                  tol
);
    import rbstc_pkg::*;

    logic [TOL_W-1:0] position_reg, position_next;
    logic [TOL_W-1:0] rotation_reg, rotation_next;
    logic [TOL_W-1:0] velocity_reg, velocity_next;
    logic [SQ_W-1:0]  position_sq_reg, position_sq_next;
    logic [SQ_W-1:0]  velocity_sq_reg, velocity_sq_next;
    logic [SQ_W-1:0]  wdata_sq;
    logic             wr_en;
    reg_index_t       index;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign index    = reg_index_t'(paddr[ADDR_W-1:2]);
    assign wdata_sq = SQ_W'(pwdata[TOL_W-1:0]) * SQ_W'(pwdata[TOL_W-1:0]);

    always_comb
    begin
        position_next    = position_reg;
        rotation_next    = rotation_reg;
        velocity_next    = velocity_reg;
        position_sq_next = position_sq_reg;
        velocity_sq_next = velocity_sq_reg;
        if (wr_en)
        begin
            case (index)
                REG_POSITION:
                begin
                    position_next    = pwdata[TOL_W-1:0];
                    position_sq_next = wdata_sq;
                end
                REG_ROTATION:
                begin
                    rotation_next = pwdata[TOL_W-1:0];
                end
                REG_VELOCITY:
                begin
                    velocity_next    = pwdata[TOL_W-1:0];
                    velocity_sq_next = wdata_sq;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            rotation_reg    <= '0;
            velocity_reg    <= '0;
            position_sq_reg <= '0;
            velocity_sq_reg <= '0;
        end
        else
        begin
            position_reg    <= position_next;
            rotation_reg    <= rotation_next;
            velocity_reg    <= velocity_next;
            position_sq_reg <= position_sq_next;
            velocity_sq_reg <= velocity_sq_next;
        end
    end

    always_comb
    begin
        case (index)
            REG_POSITION: prdata = DATA_W'(position_reg);
            REG_ROTATION: prdata = DATA_W'(rotation_reg);
            REG_VELOCITY: prdata = DATA_W'(velocity_reg);
            default:      prdata = '0;
        endcase
    end

    assign tol.position_sq = position_sq_reg;
    assign tol.velocity_sq = velocity_sq_reg;
    assign tol.rotation    = rotation_reg;

endmodule

`default_nettype wire

FILE: rtl/rbstc_eval.sv
`default_nettype none

module rbstc_eval (
    input  rbstc_pkg::req_t req,
    input  rbstc_pkg::tol_t tol,
    output logic            states_match
);
    import rbstc_pkg::*;

    function automatic logic [SUM_W-1:0] dist_sq(logic [VEC_W-1:0] a, logic [VEC_W-1:0] b);
        logic signed [LANE_W:0]     d;
        logic signed [2*LANE_W+1:0] p;
        logic [SUM_W-1:0]           s;
        s = '0;
        for (int i = 0; i < 3; i++)
        begin
            d = $signed({a[LANE_W*i+LANE_W-1], a[LANE_W*i +: LANE_W]})
              - $signed({b[LANE_W*i+LANE_W-1], b[LANE_W*i +: LANE_W]});
            p = d * d;
            s = s + SUM_W'(p[2*LANE_W-1:0]);
        end
        return s;
    endfunction

    function automatic logic [SUM_W-1:0] abs_dot(logic [ROT_W-1:0] a, logic [ROT_W-1:0] b);
        logic signed [2*LANE_W-1:0] p;
        logic signed [SUM_W-1:0]    s;
        s = '0;
        for (int i = 0; i < 4; i++)
        begin
            p = $signed(a[LANE_W*i +: LANE_W]) * $signed(b[LANE_W*i +: LANE_W]);
            s = s + {{(SUM_W-2*LANE_W){p[2*LANE_W-1]}}, p};
        end
        return s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    endfunction

    logic             position_ok;
    logic             rotation_ok;
    logic             linear_ok;
    logic             angular_ok;
    logic [CMP_W-1:0] rot_sum;

    assign position_ok = dist_sq(req.first_position, req.second_position)
                         <= SUM_W'(tol.position_sq);
    assign linear_ok   = dist_sq(req.first_linear_velocity, req.second_linear_velocity)
                         <= SUM_W'(tol.velocity_sq);
    assign angular_ok  = dist_sq(req.first_angular_velocity, req.second_angular_velocity)
                         <= SUM_W'(tol.velocity_sq);

    // One minus |dot| within tolerance is the same as |dot| plus tolerance reaching one.
    assign rot_sum     = CMP_W'(abs_dot(req.first_rotation, req.second_rotation))
                       + (CMP_W'(tol.rotation) << ROT_SHIFT);
    assign rotation_ok = rot_sum >= ONE_Q28;

    assign states_match = position_ok && rotation_ok && linear_ok && angular_ok;

endmodule

`default_nettype wire

FILE: rtl/rigid_body_state_tolerance_compare.sv
`default_nettype none
`include "rigid_body_state_tolerance_compare_assert.svh"

// Compares two rigid-body states per request and returns one states_match bit per request.
// A request is taken into an input register, checked in a single stage of parallel lane
// multipliers and compares, and its result lands in an output register; a new request is
// accepted every cycle while the result side keeps up.
// Tolerances are written through the APB port at 0x0 (position), 0x4 (rotation) and 0x8
// (velocity); the squared position and velocity tolerances are formed at write time.

module rigid_body_state_tolerance_compare (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    rbstc_req_if.sink                        req,
    rbstc_res_if.source                      res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rbstc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [rbstc_pkg::DATA_W-1:0] pwdata,
    output logic      [rbstc_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import rbstc_pkg::*;

    tol_t tol;
    req_t req_payload;
    req_t stage_reg;
    logic stage_valid_reg, stage_valid_next;
    logic res_valid_reg, res_valid_next;
    logic res_match_reg;
    logic match;
    logic advance;
    logic accept;

    rbstc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tol     (tol)
    );

    rbstc_eval u_eval (
        .req          (stage_reg),
        .tol          (tol),
        .states_match (match)
    );

    assign req_payload.first_position          = req.first_position;
    assign req_payload.second_position         = req.second_position;
    assign req_payload.first_rotation          = req.first_rotation;
    assign req_payload.second_rotation         = req.second_rotation;
    assign req_payload.first_linear_velocity   = req.first_linear_velocity;
    assign req_payload.second_linear_velocity  = req.second_linear_velocity;
    assign req_payload.first_angular_velocity  = req.first_angular_velocity;
    assign req_payload.second_angular_velocity = req.second_angular_velocity;

    assign advance   = !res_valid_reg || res.ready;
    assign req.ready = !stage_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        res_valid_next   = res_valid_reg;
        if (req.ready)
        begin
            stage_valid_next = req.valid;
        end
        if (advance)
        begin
            res_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= req_payload;
        end
        if (advance && stage_valid_reg)
        begin
            res_match_reg <= match;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.states_match = res_match_reg;

    `RBSTC_ASSERT(a_accept_fills_stage, accept |=> stage_valid_reg,
                  "accepted request did not reach the input register")
    `RBSTC_ASSERT(a_stage_moves_to_result,
                  (stage_valid_reg && advance) |=> (res_valid_reg && res_match_reg == $past(match)),
                  "evaluated request did not reach the result register")
    `RBSTC_ASSERT(a_no_overwrite_when_blocked,
                  (stage_valid_reg && res_valid_reg && !res.ready) |=>
                  (stage_valid_reg && $stable(stage_reg)),
                  "input register changed while the result side was stalled")

endmodule

`default_nettype wire

FILE: bench/rigid_body_state_tolerance_compare_tb.sv
`timescale 1ns / 100ps

module rigid_body_state_tolerance_compare_tb;
    import rbstc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 300;
    localparam int UNUSED_INDEX = 3;
    localparam logic [ADDR_W-1:0] POSITION_ADDR = ADDR_W'(4 * int'(REG_POSITION));
    localparam logic [ADDR_W-1:0] ROTATION_ADDR = ADDR_W'(4 * int'(REG_ROTATION));
    localparam logic [ADDR_W-1:0] VELOCITY_ADDR = ADDR_W'(4 * int'(REG_VELOCITY));
    localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4 * UNUSED_INDEX);
    localparam longint UNIT_DOT = longint'(1) << 28;
    localparam logic [ROT_W-1:0] UNIT_QUAT = {16'h4000, 48'h0};
    localparam logic [ROT_W-1:0] FLIPPED_UNIT_QUAT = {16'hC000, 48'h0};

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    rbstc_req_if req_bus ();
    rbstc_res_if res_bus ();

    rigid_body_state_tolerance_compare i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_bus),
        .res(res_bus),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    logic [TOL_W-1:0] position_tol = '0;
    logic [TOL_W-1:0] rotation_tol = '0;
    logic [TOL_W-1:0] velocity_tol = '0;

    req_t pending_requests[$];
    logic expected_matches[$];
    req_t offered;
    logic res_hold = 1'b0;

    int pushed_total = 0;
    int accepted_total = 0;
    int results_checked = 0;
    int matches_seen = 0;
    int mismatches = 0;
    int input_stall_cycles = 0;
    int settings_used = 1;
    int send_wait = 0;
    int send_quiet = 0;
    int res_wait = 0;
    int res_quiet = 0;
    int cycle_count = 0;

    function automatic bit vector_close(input logic [VEC_W-1:0] a, input logic [VEC_W-1:0] b,
                                        input logic [TOL_W-1:0] tol);
        longint sum;
        longint d;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            d = longint'($signed(a[LANE_W*i +: LANE_W])) - longint'($signed(b[LANE_W*i +: LANE_W]));
            sum += d * d;
        end
        return sum <= longint'(tol) * longint'(tol);
    endfunction

    function automatic bit rotation_close(input logic [ROT_W-1:0] a, input logic [ROT_W-1:0] b,
                                          input logic [TOL_W-1:0] tol);
        longint dot;
        dot = 0;
        for (int i = 0; i < 4; i++)
        begin
            dot += longint'($signed(a[LANE_W*i +: LANE_W])) *
                   longint'($signed(b[LANE_W*i +: LANE_W]));
        end
        if (dot < 0)
        begin
            dot = -dot;
        end
        return (UNIT_DOT - dot) <= (longint'(tol) << ROT_SHIFT);
    endfunction

    function automatic logic predict_states_match(input req_t r);
        return vector_close(r.first_position, r.second_position, position_tol)
            && rotation_close(r.first_rotation, r.second_rotation, rotation_tol)
            && vector_close(r.first_linear_velocity, r.second_linear_velocity, velocity_tol)
            && vector_close(r.first_angular_velocity, r.second_angular_velocity, velocity_tol);
    endfunction

    function automatic int draw_wait(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            quiet = $urandom_range(16, 64);
            return 0;
        end
        if ($urandom_range(0, 2) == 0)
        begin
            return $urandom_range(0, 17);
        end
        return $urandom_range(0, 2);
    endfunction

    function automatic int spread(input int reach);
        return int'($urandom_range(0, 2 * reach)) - reach;
    endfunction

    function automatic int reach_for(input logic [TOL_W-1:0] tol);
        if ($urandom_range(0, 3) != 0)
        begin
            return int'(tol) / 4;
        end
        return 2 * int'(tol) + 1;
    endfunction

    function automatic logic [ROT_W-1:0] nudge_lanes(input logic [ROT_W-1:0] v, input int lanes,
                                                     input int reach);
        logic [ROT_W-1:0] r;
        r = v;
        for (int i = 0; i < lanes; i++)
        begin
            r[LANE_W*i +: LANE_W] = r[LANE_W*i +: LANE_W] + LANE_W'(spread(reach));
        end
        return r;
    endfunction

    function automatic logic [VEC_W-1:0] random_vector();
        return VEC_W'({$urandom, $urandom});
    endfunction

    function automatic req_t random_request();
        req_t r;
        logic [ROT_W-1:0] q;
        int axis;
        int reach;
        int pull;
        r = '0;
        if ($urandom_range(0, 99) < 15)
        begin
            for (int w = 0; w < $bits(req_t) / 32; w++)
            begin
                r[32*w +: 32] = $urandom;
            end
            return r;
        end
        r.first_position = random_vector();
        r.second_position = VEC_W'(nudge_lanes(ROT_W'(r.first_position), 3,
                                               reach_for(position_tol)));
        r.first_linear_velocity = random_vector();
        r.second_linear_velocity = VEC_W'(nudge_lanes(ROT_W'(r.first_linear_velocity), 3,
                                                      reach_for(velocity_tol)));
        r.first_angular_velocity = random_vector();
        r.second_angular_velocity = VEC_W'(nudge_lanes(ROT_W'(r.first_angular_velocity), 3,
                                                       reach_for(velocity_tol)));
        reach = reach_for(rotation_tol);
        axis = $urandom_range(0, 3);
        pull = (reach > 16384) ? 16384 : reach;
        for (int i = 0; i < 4; i++)
        begin
            q[LANE_W*i +: LANE_W] = LANE_W'(spread(reach / 2));
        end
        q[LANE_W*axis +: LANE_W] = LANE_W'(16384 - int'($urandom_range(0, pull)));
        if ($urandom_range(0, 1) == 1)
        begin
            q[LANE_W*axis +: LANE_W] = -q[LANE_W*axis +: LANE_W];
        end
        r.first_rotation = q;
        q = nudge_lanes(q, 4, reach);
        if ($urandom_range(0, 1) == 1)
        begin
            for (int i = 0; i < 4; i++)
            begin
                q[LANE_W*i +: LANE_W] = -q[LANE_W*i +: LANE_W];
            end
        end
        r.second_rotation = q;
        return r;
    endfunction

    function automatic req_t calm_pair();
        req_t r;
        r.first_position = 48'h0300_FE80_0040;
        r.second_position = r.first_position;
        r.first_rotation = UNIT_QUAT;
        r.second_rotation = UNIT_QUAT;
        r.first_linear_velocity = 48'hFF00_0100_0020;
        r.second_linear_velocity = r.first_linear_velocity;
        r.first_angular_velocity = 48'h0010_FFF0_0200;
        r.second_angular_velocity = r.first_angular_velocity;
        return r;
    endfunction

    task automatic queue_request(input req_t r);
        pending_requests.push_back(r);
        pushed_total++;
    endtask

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            queue_request(random_request());
        end
    endtask

    task automatic drain_results();
        do
            @(posedge clk);
        while (results_checked != pushed_total);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [TOL_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            POSITION_ADDR: position_tol = value;
            ROTATION_ADDR: rotation_tol = value;
            VELOCITY_ADDR: velocity_tol = value;
            default: ;
        endcase
    endtask

    task automatic set_tolerances(input logic [TOL_W-1:0] pos, input logic [TOL_W-1:0] rot,
                                  input logic [TOL_W-1:0] vel);
        write_register(POSITION_ADDR, pos);
        write_register(ROTATION_ADDR, rot);
        write_register(VELOCITY_ADDR, vel);
        settings_used++;
    endtask

    function automatic logic [TOL_W-1:0] random_tolerance();
        case ($urandom_range(0, 3))
            0: return TOL_W'($urandom_range(0, 15));
            1: return TOL_W'($urandom_range(0, 16'h03FF));
            2: return TOL_W'($urandom_range(0, 16'h3FFF));
            default: return TOL_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** rigid_body_state_tolerance_compare: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                expected_matches.push_back(predict_states_match(offered));
                accepted_total++;
            end
            if (req_bus.valid && !req_bus.ready)
            begin
                input_stall_cycles++;
            end
            else if (send_wait > 0)
            begin
                send_wait--;
                req_bus.valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                offered = pending_requests.pop_front();
                req_bus.first_position <= offered.first_position;
                req_bus.second_position <= offered.second_position;
                req_bus.first_rotation <= offered.first_rotation;
                req_bus.second_rotation <= offered.second_rotation;
                req_bus.first_linear_velocity <= offered.first_linear_velocity;
                req_bus.second_linear_velocity <= offered.second_linear_velocity;
                req_bus.first_angular_velocity <= offered.first_angular_velocity;
                req_bus.second_angular_velocity <= offered.second_angular_velocity;
                req_bus.valid <= 1'b1;
                send_wait = draw_wait(send_quiet);
            end
            else
            begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
        end
        else
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (expected_matches.size() == 0)
                begin
                    $display("%0t: states_match expected nothing, got %0b", $time,
                             res_bus.states_match);
                    mismatches++;
                end
                else
                begin
                    if (expected_matches[0] !== res_bus.states_match)
                    begin
                        $display("%0t: states_match expected %0b, got %0b", $time,
                                 expected_matches[0], res_bus.states_match);
                        mismatches++;
                    end
                    if (expected_matches[0] === 1'b1)
                    begin
                        matches_seen++;
                    end
                    void'(expected_matches.pop_front());
                end
                results_checked++;
                res_wait = draw_wait(res_quiet);
            end
            if (res_wait > 0)
            begin
                res_wait--;
                res_bus.ready <= 1'b0;
            end
            else
            begin
                res_bus.ready <= !res_hold;
            end
        end
    end

    // Hold the result side off long enough that the pipeline fills and the request side stalls.
    initial
    begin
        do
            @(posedge clk);
        while (accepted_total < 400 || pending_requests.size() < 60);
        res_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        res_hold <= 1'b0;
    end

    initial
    begin
        req_t r;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_bus.valid = 1'b0;
        req_bus.first_position = '0;
        req_bus.second_position = '0;
        req_bus.first_rotation = '0;
        req_bus.second_rotation = '0;
        req_bus.first_linear_velocity = '0;
        req_bus.second_linear_velocity = '0;
        req_bus.first_angular_velocity = '0;
        req_bus.second_angular_velocity = '0;
        res_bus.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Zero tolerances straight out of reset.
        r = '0;
        queue_request(r);
        queue_request(calm_pair());
        r = calm_pair();
        r.second_rotation = FLIPPED_UNIT_QUAT;
        queue_request(r);
        r = calm_pair();
        r.second_position[15:0] = r.first_position[15:0] + 16'h0001;
        queue_request(r);
        r = calm_pair();
        r.first_rotation = {4{16'h7FFF}};
        r.second_rotation = {4{16'h7FFF}};
        queue_request(r);
        r = calm_pair();
        r.first_rotation = {4{16'h8000}};
        r.second_rotation = {4{16'h8000}};
        queue_request(r);
        r = '1;
        queue_request(r);
        r.first_position = {3{16'h7FFF}};
        r.second_position = {3{16'h8000}};
        r.first_rotation = {4{16'h7FFF}};
        r.second_rotation = {4{16'h8000}};
        r.first_linear_velocity = {3{16'h7FFF}};
        r.second_linear_velocity = {3{16'h8000}};
        r.first_angular_velocity = {3{16'h8000}};
        r.second_angular_velocity = {3{16'h7FFF}};
        queue_request(r);
        queue_random(150);
        drain_results();

        // Differences that sit exactly on, and one step past, each tolerance.
        set_tolerances(16'h0300, 16'h0040, 16'h0180);
        write_register(UNUSED_ADDR, 16'hFFFF);
        r = calm_pair();
        r.second_position[15:0] = r.first_position[15:0] + 16'h0300;
        queue_request(r);
        r = calm_pair();
        r.second_position[15:0] = r.first_position[15:0] + 16'h0301;
        queue_request(r);
        r = calm_pair();
        r.second_rotation[63:48] = 16'h3FC0;
        queue_request(r);
        r = calm_pair();
        r.second_rotation[63:48] = 16'h3FBF;
        queue_request(r);
        r = calm_pair();
        r.second_linear_velocity[47:32] = r.first_linear_velocity[47:32] - 16'h0180;
        queue_request(r);
        r = calm_pair();
        r.second_angular_velocity[31:16] = r.first_angular_velocity[31:16] + 16'h0181;
        queue_request(r);
        queue_random(150);
        drain_results();

        // Widest tolerances.
        set_tolerances(16'hFFFF, 16'hFFFF, 16'hFFFF);
        r = calm_pair();
        r.first_position[15:0] = 16'h7FFF;
        r.second_position[15:0] = 16'h8000;
        queue_request(r);
        r = calm_pair();
        r.first_position = {3{16'h7FFF}};
        r.second_position = {3{16'h8000}};
        queue_request(r);
        r = calm_pair();
        r.first_rotation = '0;
        r.second_rotation = '0;
        queue_request(r);
        queue_random(150);
        drain_results();

        for (int s = 0; s < 4; s++)
        begin
            set_tolerances(random_tolerance(), random_tolerance(), random_tolerance());
            queue_random(150);
            drain_results();
        end

        set_tolerances(16'hFFFF, 16'h0000, 16'hFFFF);
        queue_random(100);
        drain_results();
        set_tolerances(16'h0000, 16'hFFFF, 16'h0000);
        queue_random(100);
        drain_results();
        set_tolerances(16'h0000, 16'h0000, 16'h0000);
        queue_random(100);
        drain_results();

        $display("Checked %0d comparisons (%0d matching) over %0d tolerance settings.",
                 results_checked, matches_seen, settings_used);
        $display("The request side was stalled by the block for %0d cycles.", input_stall_cycles);
        if (mismatches == 0 && expected_matches.size() == 0)
        begin
            $display("** rigid_body_state_tolerance_compare: PASSED **");
        end
        else
        begin
            $display("** rigid_body_state_tolerance_compare: FAILED **");
        end
        $finish;
    end

endmodule
